// ----- hdl/adss_pkg.sv -----
// Shared constants and types for the averaged deadband step stabilizer.
package adss_pkg;

  localparam int MAX_OVERSAMPLE_DEF = 1024;
  localparam int SAMPLE_WIDTH_DEF   = 32;

  localparam int SMP_W     = 32;
  localparam int OUT_W     = 32;
  localparam int SUM_W     = 43;
  localparam int CNT_W     = 11;
  localparam int DB_W      = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int MODE_W    = 2;

  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FINISHED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COLLECT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STABILIZE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLING = 2'd3;

  localparam logic [DB_W-1:0]  STEP_SIZE_RST    = 31'd1;
  localparam logic [CNT_W-1:0] OVERSAMPLING_RST = 11'd16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// ----- hdl/adss_if.sv -----
// Valid/ready channel interfaces for command words and result words.
interface adss_in_if;
  logic                             valid;
  logic                             ready;
  logic [adss_pkg::CMD_W-1:0]       cmd;
  logic signed [adss_pkg::SMP_W-1:0] sample;
  logic signed [adss_pkg::OUT_W-1:0] current_output;

  modport source(output valid, cmd, sample, current_output, input ready);
  modport sink(input valid, cmd, sample, current_output, output ready);
endinterface

interface adss_out_if;
  logic                              valid;
  logic                              ready;
  logic                              write_valid;
  logic signed [adss_pkg::OUT_W-1:0] write_value;
  logic                              active;
  logic                              adjusted;
  logic [adss_pkg::MODE_W-1:0]       mode_out;

  modport source(output valid, write_valid, write_value, active, adjusted, mode_out,
                 input ready);
  modport sink(input valid, write_valid, write_value, active, adjusted, mode_out,
               output ready);
endinterface

// ----- hdl/averaged_deadband_step_stabilizer.sv -----
// Top level: command sequencer, sample accumulator and iterative mean divider.
// Every command word yields its result word, registered, in the cycle after accept.
// Throughput: one command word per cycle while results are taken, except the
//   averaging tick, after which the block is busy for 43 restoring-divide steps of
//   a single shared 13-bit subtractor, then a state to sign and saturate the mean.
// Reset: synchronous active-low rst_n; registers return to their reset values,
//   mode finished, sum/count/mean cleared, no result pending.
module averaged_deadband_step_stabilizer #(
  parameter int MAX_OVERSAMPLE = adss_pkg::MAX_OVERSAMPLE_DEF,
  parameter int SAMPLE_WIDTH   = adss_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  adss_in_if.sink                           in_ch,
  adss_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [adss_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [adss_pkg::CFG_W-1:0]        cfg_wdata
);

  // Effective sample width is capped at the field width.
  localparam int SW_EFF  = (SAMPLE_WIDTH > adss_pkg::SMP_W) ? adss_pkg::SMP_W : SAMPLE_WIDTH;
  localparam int SMP_SH  = adss_pkg::SMP_W - SW_EFF;
  // Count register is 11 bits, so any cap above its range never binds.
  localparam int CNT_MAX = (1 << adss_pkg::CNT_W) - 1;
  localparam int CAP_INT = (MAX_OVERSAMPLE > CNT_MAX) ? CNT_MAX : MAX_OVERSAMPLE;
  localparam logic [adss_pkg::CNT_W-1:0] LIMIT_CAP = adss_pkg::CNT_W'(CAP_INT);
  localparam logic [adss_pkg::DIV_CNT_W-1:0] DIV_LAST =
    adss_pkg::DIV_CNT_W'(adss_pkg::SUM_W - 1);

  localparam logic signed [33:0] SAT_MAX34 = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN34 = -34'sh0_8000_0000;

  // Configuration registers
  logic signed [adss_pkg::OUT_W-1:0] setpoint_r;
  logic [adss_pkg::DB_W-1:0]         deadband_r;
  logic [adss_pkg::DB_W-1:0]         step_r;
  logic [adss_pkg::CNT_W-1:0]        ovs_r;

  // Run state
  adss_pkg::state_t                  state_r, state_nxt;
  logic [adss_pkg::MODE_W-1:0]       mode_r, mode_nxt;
  logic signed [adss_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [adss_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [adss_pkg::OUT_W-1:0] mean_r, mean_nxt;
  logic                              running_r, running_nxt;
  logic                              changed_r, changed_nxt;

  // Divider: dividend shifts out the top while quotient bits shift in below
  logic [adss_pkg::SUM_W-1:0]        div_q_r, div_q_nxt;
  logic [adss_pkg::CNT_W-1:0]        div_rem_r, div_rem_nxt;
  logic [adss_pkg::DIV_CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic                              div_neg_r, div_neg_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_wv_r, out_wv_nxt;
  logic signed [adss_pkg::OUT_W-1:0] out_wval_r, out_wval_nxt;
  logic                              out_active_r, out_active_nxt;
  logic                              out_adj_r, out_adj_nxt;
  logic [adss_pkg::MODE_W-1:0]       out_mode_r, out_mode_nxt;

  logic                              in_acc;
  logic [adss_pkg::CNT_W-1:0]        limit;
  logic signed [adss_pkg::SMP_W-1:0] smp;
  logic [adss_pkg::SUM_W-1:0]        sum_abs;
  logic signed [32:0]                err;
  logic signed [32:0]                db33;
  logic                              out_of_band;
  logic signed [33:0]                step_val;
  logic [adss_pkg::CNT_W:0]          rem_sh;
  logic [adss_pkg::CNT_W+1:0]        rem_diff;
  logic                              qbit;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > SAT_MAX34)      sat32 = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN34) sat32 = 32'sh8000_0000;
    else                    sat32 = v[31:0];
  endfunction

  assign in_ch.ready  = (state_r == adss_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_valid = out_wv_r;
  assign out_ch.write_value = out_wval_r;
  assign out_ch.active      = out_active_r;
  assign out_ch.adjusted    = out_adj_r;
  assign out_ch.mode_out    = out_mode_r;

  assign limit   = (ovs_r > LIMIT_CAP) ? LIMIT_CAP : ovs_r;
  assign smp     = (in_ch.sample <<< SMP_SH) >>> SMP_SH;
  assign sum_abs = sum_r[adss_pkg::SUM_W-1] ? adss_pkg::SUM_W'(-sum_r)
                                            : adss_pkg::SUM_W'(sum_r);

  // Deadband test: error inside [-db, +db] counts as settled
  assign err         = {mean_r[31], mean_r} - {setpoint_r[31], setpoint_r};
  assign db33        = $signed({2'b00, deadband_r});
  assign out_of_band = (err > db33) || (err < -db33);
  // Step against the sign of the error
  assign step_val    = (err > 33'sd0)
                     ? {{2{in_ch.current_output[31]}}, in_ch.current_output} - $signed({3'b000, step_r})
                     : {{2{in_ch.current_output[31]}}, in_ch.current_output} + $signed({3'b000, step_r});

  // One restoring-divide step
  assign rem_sh   = {div_rem_r, div_q_r[adss_pkg::SUM_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, cnt_r};
  assign qbit     = !rem_diff[adss_pkg::CNT_W+1];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    mean_nxt       = mean_r;
    running_nxt    = running_r;
    changed_nxt    = changed_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    div_neg_nxt    = div_neg_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_wv_nxt     = out_wv_r;
    out_wval_nxt   = out_wval_r;
    out_active_nxt = out_active_r;
    out_adj_nxt    = out_adj_r;
    out_mode_nxt   = out_mode_r;

    unique case (state_r)
      adss_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_wv_nxt   = 1'b0;
          out_wval_nxt = '0;
          case (in_ch.cmd)
            adss_pkg::CMD_START: begin
              changed_nxt = 1'b0;
              sum_nxt     = '0;
              cnt_nxt     = '0;
              mode_nxt    = adss_pkg::MODE_COLLECT;
              running_nxt = 1'b1;
            end
            adss_pkg::CMD_STOP: begin
              running_nxt = 1'b0;
              mode_nxt    = adss_pkg::MODE_FINISHED;
              sum_nxt     = '0;
              cnt_nxt     = '0;
            end
            adss_pkg::CMD_TICK: begin
              if (mode_r == adss_pkg::MODE_COLLECT) begin
                if (cnt_r < limit) begin
                  sum_nxt = sum_r + {{(adss_pkg::SUM_W-adss_pkg::SMP_W){smp[31]}}, smp};
                  cnt_nxt = cnt_r + 1'b1;
                end else begin
                  mode_nxt = adss_pkg::MODE_STABILIZE;
                  if (cnt_r == '0) begin
                    mean_nxt = '0;
                  end else begin
                    // Mean is finished in the background; block stays busy
                    div_q_nxt   = sum_abs;
                    div_rem_nxt = '0;
                    div_cnt_nxt = '0;
                    div_neg_nxt = sum_r[adss_pkg::SUM_W-1];
                    state_nxt   = adss_pkg::ST_DIV;
                  end
                end
              end else if (mode_r == adss_pkg::MODE_STABILIZE) begin
                sum_nxt = '0;
                cnt_nxt = '0;
                if (out_of_band) begin
                  out_wv_nxt   = 1'b1;
                  out_wval_nxt = sat32(step_val);
                  changed_nxt  = 1'b1;
                  mode_nxt     = adss_pkg::MODE_COLLECT;
                  running_nxt  = 1'b1;
                end else begin
                  mode_nxt    = adss_pkg::MODE_FINISHED;
                  running_nxt = 1'b0;
                end
              end
            end
            default: ;  // unused code: report state only
          endcase
          out_valid_nxt  = 1'b1;
          out_active_nxt = running_nxt;
          out_adj_nxt    = changed_nxt;
          out_mode_nxt   = mode_nxt;
        end
      end
      adss_pkg::ST_DIV: begin
        div_rem_nxt = qbit ? rem_diff[adss_pkg::CNT_W-1:0] : rem_sh[adss_pkg::CNT_W-1:0];
        div_q_nxt   = {div_q_r[adss_pkg::SUM_W-2:0], qbit};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) state_nxt = adss_pkg::ST_FIN;
      end
      adss_pkg::ST_FIN: begin
        // Apply sign, saturate to 32-bit signed
        if (!div_neg_r) begin
          mean_nxt = (div_q_r > adss_pkg::SUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                 : div_q_r[31:0];
        end else begin
          mean_nxt = (div_q_r > adss_pkg::SUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                                 : -div_q_r[31:0];
        end
        state_nxt = adss_pkg::ST_IDLE;
      end
      default: state_nxt = adss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= '0;
      deadband_r  <= '0;
      step_r      <= adss_pkg::STEP_SIZE_RST;
      ovs_r       <= adss_pkg::OVERSAMPLING_RST;
      state_r     <= adss_pkg::ST_IDLE;
      mode_r      <= adss_pkg::MODE_FINISHED;
      sum_r       <= '0;
      cnt_r       <= '0;
      mean_r      <= '0;
      running_r   <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          adss_pkg::CFG_SETPOINT:     setpoint_r <= cfg_wdata;
          adss_pkg::CFG_DEADBAND:     deadband_r <= cfg_wdata[adss_pkg::DB_W-1:0];
          adss_pkg::CFG_STEP_SIZE:    step_r     <= cfg_wdata[adss_pkg::DB_W-1:0];
          adss_pkg::CFG_OVERSAMPLING: ovs_r      <= cfg_wdata[adss_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      mean_r      <= mean_nxt;
      running_r   <= running_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    div_neg_r    <= div_neg_nxt;
    out_wv_r     <= out_wv_nxt;
    out_wval_r   <= out_wval_nxt;
    out_active_r <= out_active_nxt;
    out_adj_r    <= out_adj_nxt;
    out_mode_r   <= out_mode_nxt;
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == adss_pkg::ST_IDLE)
    else $error("ready while divider busy");

  a_running_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (mode_r != adss_pkg::MODE_FINISHED))
    else $error("running flag out of step with mode");

  a_div_in_stabilize: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != adss_pkg::ST_IDLE) |-> mode_r == adss_pkg::MODE_STABILIZE)
    else $error("divider running outside stabilize mode");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == adss_pkg::ST_DIV && div_cnt_r == DIV_LAST) |=> state_r == adss_pkg::ST_FIN)
    else $error("divider overran its step count");

  a_write_implies_adjusted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wv_r) |-> (out_adj_r && out_active_r))
    else $error("write word without adjusted/active");
`endif

endmodule
